// ===== src/kms_pkg.sv =====
// shared types and constants for the key matrix scanner
package kms_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // item kinds carried by the action field
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // report layout and key code ranges
    localparam int          REPORT_SLOTS = 6;
    localparam int          LEVEL_WIDTH  = 14;
    localparam logic [15:0] MOD_FIRST    = 16'h00E0;
    localparam logic [15:0] MOD_LAST     = 16'h00E7;
    localparam logic [15:0] FN_RESET     = 16'd240;

endpackage

// ===== src/key_matrix_scan_hid_report.sv =====
// key matrix scanner that keeps a 6-key HID boot report, one column per cycle
// a scan beat reads its row of the keymap through the read port; both kinds of beat end
// in the finish step, which loads the output register once the old result is taken; a new
// beat is taken only when idle, so not before the last result is loaded
// reset (synchronous, active low) clears the report, pressed bits, Fn flag and row, sets
// fn_code to FN_RESET; the keymap is not cleared and must be loaded before its keys are
// scanned
module key_matrix_scan_hid_report #(
    parameter int ROWS      = 6,
    parameter int COLUMNS   = 14,
    parameter int KEY_SLOTS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [13:0] i_column_levels,
    input  logic [3:0]  i_map_column,
    input  logic [2:0]  i_map_row,
    input  logic [15:0] i_map_code,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_modifier_bits,
    output logic [7:0]  o_slot_one,
    output logic [7:0]  o_slot_two,
    output logic [7:0]  o_slot_three,
    output logic [7:0]  o_slot_four,
    output logic [7:0]  o_slot_five,
    output logic [7:0]  o_slot_six,
    output logic        o_fn_held,
    output logic        o_report_changed,
    output logic [2:0]  o_next_row
);
    import kms_pkg::*;

    localparam int NK   = ROWS * COLUMNS;
    localparam int AW   = (NK > 1) ? $clog2(NK) : 1;
    localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CNTW = $clog2(COLUMNS + 1);

    // sequencer and scan pipeline
    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_pv, n_pv;
    logic [AW-1:0]     r_pidx, n_pidx;
    logic [CW-1:0]     r_pcol, n_pcol;
    logic [13:0]       r_levels, n_levels;
    logic [15:0]       r_code;

    // report state
    logic [NK-1:0]     r_pressed, n_pressed;
    logic [7:0]        r_mod, n_mod;
    logic [7:0]        r_slot [REPORT_SLOTS];
    logic [7:0]        n_slot [REPORT_SLOTS];
    logic [2:0]        r_used, n_used;
    logic              r_fn, n_fn;
    logic [2:0]        r_scan_row, n_scan_row;
    logic              r_changed, n_changed;
    logic [15:0]       r_fn_code;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_o_mod, n_o_mod;
    logic [7:0]        r_o_slot [REPORT_SLOTS];
    logic [7:0]        n_o_slot [REPORT_SLOTS];
    logic              r_o_fn, n_o_fn;
    logic              r_o_changed, n_o_changed;
    logic [2:0]        r_o_row, n_o_row;

    // keymap memory
    logic [15:0]       mem [NK];
    logic              rd_en;
    logic              map_we;
    logic [AW-1:0]     wr_addr;

    logic              in_acc;
    logic [2:0]        row_sel;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign row_sel    = (32'(r_scan_row) < ROWS) ? r_scan_row : 3'd0;

    // keymap load decode and read enable
    always_comb begin
        map_we  = in_acc && (i_action == ACT_LOAD) && (32'(i_map_row) < ROWS)
                  && (32'(i_map_column) < COLUMNS);
        wr_addr = AW'(32'(i_map_row) * COLUMNS + 32'(i_map_column));
        rd_en   = (r_state == ST_SCAN) && (32'(r_cnt) < COLUMNS);
    end

    // keymap write port and registered read port
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem[wr_addr] <= i_map_code;
        end
        if (rd_en) begin
            r_code <= mem[r_addr];
        end
    end

    // sequencer, per-column press/release unit and output load
    always_comb begin
        logic [31:0] col_ext;
        logic        down;
        logic        was;
        logic [5:0]  hit;
        logic        after;
        logic        found;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_pcol      = r_pcol;
        n_levels    = r_levels;
        n_pressed   = r_pressed;
        n_mod       = r_mod;
        n_slot      = r_slot;
        n_used      = r_used;
        n_fn        = r_fn;
        n_scan_row  = r_scan_row;
        n_changed   = r_changed;
        n_out_valid = r_out_valid;
        n_o_mod     = r_o_mod;
        n_o_slot    = r_o_slot;
        n_o_fn      = r_o_fn;
        n_o_changed = r_o_changed;
        n_o_row     = r_o_row;

        col_ext = 32'(r_pcol);
        down    = (col_ext < LEVEL_WIDTH) ? !r_levels[col_ext[3:0]] : 1'b0;
        was     = r_pressed[r_pidx];
        found   = 1'b0;
        after   = 1'b0;
        for (int k = 0; k < REPORT_SLOTS; k++) begin
            hit[k] = (k < KEY_SLOTS) && (3'(k) < r_used) && ({8'd0, r_slot[k]} == r_code);
        end

        // output register drains on a taken beat
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_changed = 1'b0;
                    if (i_action == ACT_SCAN) begin
                        n_state    = ST_SCAN;
                        n_cnt      = '0;
                        n_addr     = AW'(32'(row_sel) * COLUMNS);
                        n_levels   = i_column_levels;
                        n_scan_row = (32'(row_sel) + 1 >= ROWS) ? 3'd0 : row_sel + 3'd1;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next keymap read
                if (rd_en) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_addr = r_addr + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_addr;
                    n_pcol = CW'(r_cnt);
                end
                // handle the column whose code just came back
                if (r_pv) begin
                    if (!was && down) begin
                        if (!((32'(r_used) >= KEY_SLOTS) && (r_code < MOD_FIRST))) begin
                            n_pressed[r_pidx] = 1'b1;
                            n_changed         = 1'b1;
                            if (r_code == r_fn_code) begin
                                n_fn = 1'b1;
                            end else if (r_code >= MOD_FIRST) begin
                                if (r_code <= MOD_LAST) begin
                                    n_mod = r_mod | (8'd1 << r_code[2:0]);
                                end
                            end else if (32'(r_used) < KEY_SLOTS) begin
                                for (int k = 0; k < REPORT_SLOTS; k++) begin
                                    if (3'(k) == r_used) begin
                                        n_slot[k] = r_code[7:0];
                                    end
                                end
                                n_used = r_used + 3'd1;
                            end
                        end
                    end else if (was && !down) begin
                        n_pressed[r_pidx] = 1'b0;
                        n_changed         = 1'b1;
                        if (r_code == r_fn_code) begin
                            n_fn = 1'b0;
                        end else if (r_code >= MOD_FIRST) begin
                            if (r_code <= MOD_LAST) begin
                                n_mod = r_mod & ~(8'd1 << r_code[2:0]);
                            end
                        end else begin
                            // remove first match and close the gap
                            for (int k = 0; k < REPORT_SLOTS; k++) begin
                                after = after | hit[k];
                                if (after) begin
                                    n_slot[k] = (k + 1 < REPORT_SLOTS)
                                                ? r_slot[(k + 1) % REPORT_SLOTS] : 8'd0;
                                end
                            end
                            found = after;
                            if (found) begin
                                n_used = r_used - 3'd1;
                            end
                        end
                    end
                end
                if (!rd_en && !r_pv) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_mod     = r_mod;
                    n_o_slot    = r_slot;
                    n_o_fn      = r_fn;
                    n_o_changed = r_changed;
                    n_o_row     = r_scan_row;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and report registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_pressed   <= '0;
            r_mod       <= 8'd0;
            r_used      <= 3'd0;
            r_fn        <= 1'b0;
            r_scan_row  <= 3'd0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fn_code   <= FN_RESET;
            for (int k = 0; k < REPORT_SLOTS; k++) begin
                r_slot[k] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pv        <= n_pv;
            r_pressed   <= n_pressed;
            r_mod       <= n_mod;
            r_slot      <= n_slot;
            r_used      <= n_used;
            r_fn        <= n_fn;
            r_scan_row  <= n_scan_row;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fn_code <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pidx      <= n_pidx;
        r_pcol      <= n_pcol;
        r_levels    <= n_levels;
        r_o_mod     <= n_o_mod;
        r_o_slot    <= n_o_slot;
        r_o_fn      <= n_o_fn;
        r_o_changed <= n_o_changed;
        r_o_row     <= n_o_row;
    end

    // result ports
    assign o_out_valid      = r_out_valid;
    assign o_modifier_bits  = r_o_mod;
    assign o_slot_one       = r_o_slot[0];
    assign o_slot_two       = r_o_slot[1];
    assign o_slot_three     = r_o_slot[2];
    assign o_slot_four      = r_o_slot[3];
    assign o_slot_five      = r_o_slot[4];
    assign o_slot_six       = r_o_slot[5];
    assign o_fn_held        = r_o_fn;
    assign o_report_changed = r_o_changed;
    assign o_next_row       = r_o_row;

    // slot count never passes the slot limit
    a_used_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= KEY_SLOTS)
        else $error("slot count above limit");

    // an empty report has an empty first slot
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == 3'd0 |-> r_slot[0] == 8'd0)
        else $error("slot filled with zero count");

    // the column pipeline only runs inside a scan
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_state) == ST_SCAN)
        else $error("column stage active outside scan");

    // an accepted scan beat starts at column zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_action == ACT_SCAN |=> r_state == ST_SCAN && r_cnt == '0)
        else $error("scan did not start");

    // a result only comes out of the finish step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result without finish step");

endmodule

// ===== bench/kms_report_checker.sv =====
// checker for the key matrix scanner: predicts every hid report beat and compares it
module kms_report_checker #(
    parameter int ROWS      = 6,
    parameter int COLUMNS   = 14,
    parameter int KEY_SLOTS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_action,
    input  logic [13:0] i_column_levels,
    input  logic [3:0]  i_map_column,
    input  logic [2:0]  i_map_row,
    input  logic [15:0] i_map_code,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_modifier_bits,
    input  logic [7:0]  i_slot_one,
    input  logic [7:0]  i_slot_two,
    input  logic [7:0]  i_slot_three,
    input  logic [7:0]  i_slot_four,
    input  logic [7:0]  i_slot_five,
    input  logic [7:0]  i_slot_six,
    input  logic        i_fn_held,
    input  logic        i_report_changed,
    input  logic [2:0]  i_next_row,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_report_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_KEYS = ROWS * COLUMNS;

    typedef struct packed {
        logic [7:0]      modifiers;
        logic [5:0][7:0] slots;      // index 0 is slot one
        logic            fn_held;
        logic            changed;
        logic [2:0]      next_row;
    } t_hid_report;

    t_hid_report expected_reports[$];

    // scanner state as the block should hold it
    logic [15:0] keymap_copy  [NUM_KEYS];
    logic        pressed_copy [NUM_KEYS];
    logic [7:0]  modifier_byte;
    logic [7:0]  slot_bytes   [kms_pkg::REPORT_SLOTS];
    int          used_slots;
    logic        fn_flag;
    int          scan_row;
    logic [15:0] fn_code;
    int          fails;
    int          reports;

    // press: fn flag, modifier bit, nothing above the modifiers, or next free slot
    function automatic void press_key(input logic [15:0] code);
        if (code == fn_code) begin
            fn_flag = 1'b1;
        end else if (code >= kms_pkg::MOD_FIRST) begin
            // modifier codes run 0xE0..0xE7, so the low bits are the bit index
            if (code <= kms_pkg::MOD_LAST) modifier_byte[code[2:0]] = 1'b1;
        end else if (used_slots < KEY_SLOTS) begin
            slot_bytes[used_slots] = code[7:0];
            used_slots++;
        end
    endfunction

    // release: undo the press; a slot key drops its first match and the rest move down
    function automatic void release_key(input logic [15:0] code);
        bit found;
        found = 1'b0;
        if (code == fn_code) begin
            fn_flag = 1'b0;
        end else if (code >= kms_pkg::MOD_FIRST) begin
            if (code <= kms_pkg::MOD_LAST) modifier_byte[code[2:0]] = 1'b0;
        end else begin
            for (int k = 0; k < used_slots; k++) begin
                if (!found && slot_bytes[k] == code[7:0]) begin
                    found = 1'b1;
                    for (int j = k; j + 1 < used_slots; j++) slot_bytes[j] = slot_bytes[j + 1];
                    slot_bytes[used_slots - 1] = 8'h00;
                    used_slots--;
                end
            end
        end
    endfunction

    // one row scan, columns in order, each seeing the state left by the ones before
    function automatic logic apply_row_scan(input logic [13:0] levels);
        logic        changed;
        logic        down;
        logic [15:0] code;
        int          idx;
        changed = 1'b0;
        if (scan_row >= ROWS) scan_row = 0;
        for (int c = 0; c < COLUMNS; c++) begin
            idx  = scan_row * COLUMNS + c;
            code = keymap_copy[idx];
            down = (c < kms_pkg::LEVEL_WIDTH) ? !levels[c] : 1'b0;
            if (!pressed_copy[idx] && down) begin
                // report full: ordinary codes wait for a later scan
                if (!(used_slots >= KEY_SLOTS && code < kms_pkg::MOD_FIRST)) begin
                    pressed_copy[idx] = 1'b1;
                    changed = 1'b1;
                    press_key(code);
                end
            end else if (pressed_copy[idx] && !down) begin
                pressed_copy[idx] = 1'b0;
                changed = 1'b1;
                release_key(code);
            end
        end
        scan_row = (scan_row + 1 >= ROWS) ? 0 : scan_row + 1;
        return changed;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            fails++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        t_hid_report predicted;
        t_hid_report oldest;
        t_hid_report seen;
        logic        changed;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) pressed_copy[k] = 1'b0;
            for (int k = 0; k < kms_pkg::REPORT_SLOTS; k++) slot_bytes[k] = 8'h00;
            modifier_byte = 8'h00;
            used_slots    = 0;
            fn_flag       = 1'b0;
            scan_row      = 0;
            fn_code       = kms_pkg::FN_RESET;
            fails         = 0;
            reports       = 0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) fn_code = i_cfg_wdata;

            // input beat: update the state and queue the report it leads to
            if (i_in_valid && i_in_ready) begin
                changed = 1'b0;
                if (i_action == kms_pkg::ACT_LOAD) begin
                    if (i_map_row < ROWS && i_map_column < COLUMNS)
                        keymap_copy[i_map_row * COLUMNS + i_map_column] = i_map_code;
                end else begin
                    changed = apply_row_scan(i_column_levels);
                end
                predicted.modifiers = modifier_byte;
                for (int k = 0; k < kms_pkg::REPORT_SLOTS; k++)
                    predicted.slots[k] = slot_bytes[k];
                predicted.fn_held  = fn_flag;
                predicted.changed  = changed;
                predicted.next_row = scan_row[2:0];
                expected_reports.push_back(predicted);
            end

            // report beat: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                seen.modifiers = i_modifier_bits;
                seen.slots     = {i_slot_six, i_slot_five, i_slot_four,
                                  i_slot_three, i_slot_two, i_slot_one};
                seen.fn_held   = i_fn_held;
                seen.changed   = i_report_changed;
                seen.next_row  = i_next_row;
                if (expected_reports.size() == 0) begin
                    $display("%0t: report beat with nothing expected", $time);
                    fails++;
                end else begin
                    oldest = expected_reports.pop_front();
                    reports++;
                    compare_field("modifier_bits", 16'(oldest.modifiers),
                                  16'(seen.modifiers));
                    for (int k = 0; k < kms_pkg::REPORT_SLOTS; k++)
                        compare_field($sformatf("slot %0d", k + 1), 16'(oldest.slots[k]),
                                      16'(seen.slots[k]));
                    compare_field("fn_held", 16'(oldest.fn_held), 16'(seen.fn_held));
                    compare_field("report_changed", 16'(oldest.changed), 16'(seen.changed));
                    compare_field("next_row", 16'(oldest.next_row), 16'(seen.next_row));
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= expected_reports.size();
        o_report_count <= reports;
    end

endmodule

// ===== bench/tb_key_matrix_scan_hid_report.sv =====
// testbench top for the key matrix scanner: stimulus, idling and verdict
module tb_key_matrix_scan_hid_report;
    timeunit 1ns;
    timeprecision 1ps;

    import kms_pkg::*;

    localparam int ROWS         = 6;
    localparam int COLUMNS      = 14;
    localparam int KEY_SLOTS    = 6;
    localparam int SCAN_LATENCY = COLUMNS + 3;
    localparam int PHASE_ITEMS  = 90;
    localparam int NUM_PHASES   = 6;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        action    = ACT_SCAN;
    logic [13:0] column_levels = '1;
    logic [3:0]  map_column = 4'd0;
    logic [2:0]  map_row    = 3'd0;
    logic [15:0] map_code   = 16'h0000;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  modifier_bits;
    logic [7:0]  slot_one, slot_two, slot_three, slot_four, slot_five, slot_six;
    logic        fn_held;
    logic        report_changed;
    logic [2:0]  next_row;

    int fail_count;
    int pending;
    int report_count;
    int cycle_count = 0;
    int n_scans     = 0;
    int n_loads     = 0;

    // stimulus side view of the block
    bit          steady = 1'b0;
    int          row_now = 0;
    logic [15:0] fn_now = FN_RESET;
    bit          written   [ROWS * COLUMNS];
    logic [13:0] held_keys [ROWS];

    key_matrix_scan_hid_report #(
        .ROWS      (ROWS),
        .COLUMNS   (COLUMNS),
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (action),
        .i_column_levels  (column_levels),
        .i_map_column     (map_column),
        .i_map_row        (map_row),
        .i_map_code       (map_code),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_modifier_bits  (modifier_bits),
        .o_slot_one       (slot_one),
        .o_slot_two       (slot_two),
        .o_slot_three     (slot_three),
        .o_slot_four      (slot_four),
        .o_slot_five      (slot_five),
        .o_slot_six       (slot_six),
        .o_fn_held        (fn_held),
        .o_report_changed (report_changed),
        .o_next_row       (next_row)
    );

    kms_report_checker #(
        .ROWS      (ROWS),
        .COLUMNS   (COLUMNS),
        .KEY_SLOTS (KEY_SLOTS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_action         (action),
        .i_column_levels  (column_levels),
        .i_map_column     (map_column),
        .i_map_row        (map_row),
        .i_map_code       (map_code),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_modifier_bits  (modifier_bits),
        .i_slot_one       (slot_one),
        .i_slot_two       (slot_two),
        .i_slot_three     (slot_three),
        .i_slot_four      (slot_four),
        .i_slot_five      (slot_five),
        .i_slot_six       (slot_six),
        .i_fn_held        (fn_held),
        .i_report_changed (report_changed),
        .i_next_row       (next_row),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_report_count   (report_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports still due", cycle_count, pending);
            $display("tb_key_matrix_scan_hid_report NOT OK");
            $finish;
        end
    end

    // row 0 codes for the directed part: slots, duplicate, modifiers, fn, codes above them
    function automatic logic [15:0] directed_code(input int col);
        case (col)
            0:       return 16'h0004;
            1:       return 16'h0005;
            2:       return MOD_FIRST;
            3:       return MOD_LAST;
            4:       return FN_RESET;
            5:       return 16'hFFFF;
            6:       return 16'h0004;
            7:       return 16'h0000;
            8:       return 16'h0006;
            9:       return 16'h0007;
            10:      return 16'h0009;
            default: return 16'h00E1;
        endcase
    endfunction

    // keymap codes: often from a small pool so that duplicates occur
    function automatic logic [15:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 16'($urandom_range(16'h000B, 16'h0004));
        if (r < 50) return 16'($urandom_range(16'h00DF, 16'h0000));
        if (r < 68) return 16'($urandom_range(MOD_LAST, MOD_FIRST));
        if (r < 78) return fn_now;
        if (r < 94) return 16'($urandom_range(16'hFFFF, 16'h00E8));
        return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endfunction

    // one input beat; keys with no keymap entry yet are always shown released
    task automatic send_beat(input logic act, input logic [13:0] levels,
                             input logic [3:0] col, input logic [2:0] row,
                             input logic [15:0] code);
        logic [13:0] shown;
        shown = levels;
        if (act == ACT_SCAN) begin
            for (int c = 0; c < COLUMNS; c++)
                if (!written[row_now * COLUMNS + c]) shown[c] = 1'b1;
        end
        if (!steady && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        column_levels <= shown;
        map_column    <= col;
        map_row       <= row;
        map_code      <= code;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (act == ACT_LOAD) begin
            n_loads++;
            if (row < ROWS && col < COLUMNS) written[row * COLUMNS + col] = 1'b1;
        end else begin
            n_scans++;
            row_now = (row_now + 1) % ROWS;
        end
    endtask

    // drain every report, then let the block settle
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SCAN_LATENCY + 3) @(posedge clk);
    endtask

    initial begin
        logic [15:0] fn_value;
        logic [3:0]  col;
        logic [2:0]  row;
        int          r;
        int          key;
        for (int k = 0; k < ROWS * COLUMNS; k++) written[k] = 1'b0;
        for (int k = 0; k < ROWS; k++) held_keys[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: row 0 keymap, loads outside the matrix
        for (int c = 0; c < 12; c++) send_beat(ACT_LOAD, '1, 4'(c), 3'd0, directed_code(c));
        send_beat(ACT_LOAD, '0, 4'd15, 3'd7, 16'hFFFF);
        send_beat(ACT_LOAD, '0, 4'd14, 3'd0, 16'h1234);
        // whole row down: fills the report, the last ordinary key is held back
        send_beat(ACT_SCAN, '0, 4'd0, 3'd0, 16'h0000);
        repeat (ROWS - 1)
            send_beat(ACT_SCAN, 14'($urandom_range(16383)), 4'd0, 3'd0, 16'h0000);
        // first duplicate released, the held-back key gets its slot
        send_beat(ACT_SCAN, 14'h0001, 4'd0, 3'd0, 16'h0000);
        repeat (ROWS - 1)
            send_beat(ACT_SCAN, 14'($urandom_range(16383)), 4'd0, 3'd0, 16'h0000);
        send_beat(ACT_SCAN, '1, 4'd0, 3'd0, 16'h0000);

        // full keymap with random codes
        for (int k = 0; k < ROWS * COLUMNS; k++)
            send_beat(ACT_LOAD, 14'($urandom_range(16383)), 4'(k % COLUMNS),
                      3'(k / COLUMNS), pick_code());

        // random phases, one fn_code setting each
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1:       fn_value = 16'h0004;   // an ordinary code: fn waits when full
                    2:       fn_value = 16'h00E3;   // a modifier code
                    3:       fn_value = 16'hFFFF;
                    4:       fn_value = 16'h0000;
                    default: fn_value = FN_RESET;
                endcase
                wait_for_idle();
                cfg_we    <= 1'b1;
                cfg_wdata <= fn_value;
                fn_now     = fn_value;
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            steady = (phase == 3);
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    // keymap rewrite, now and then outside the matrix
                    if ($urandom_range(9) == 0) begin
                        col = 4'($urandom_range(15));
                        row = 3'($urandom_range(7));
                    end else begin
                        col = 4'($urandom_range(COLUMNS - 1));
                        row = 3'($urandom_range(ROWS - 1));
                    end
                    send_beat(ACT_LOAD, 14'($urandom_range(16383)), col, row, pick_code());
                end else begin
                    r   = $urandom_range(99);
                    key = $urandom_range(COLUMNS - 1);
                    if (r < 80) begin
                        // slow drift of held keys; releases come easier than presses
                        if (held_keys[row_now][key]) held_keys[row_now][key] = 1'b0;
                        else if ($urandom_range(5) == 0) held_keys[row_now][key] = 1'b1;
                    end else if (r < 90) begin
                        held_keys[row_now] = 14'($urandom_range(16383));
                    end else if (r < 94) begin
                        held_keys[row_now] = '1;
                    end else if (r < 98) begin
                        held_keys[row_now] = '0;
                    end
                    send_beat(ACT_SCAN, ~held_keys[row_now], 4'($urandom_range(15)),
                              3'($urandom_range(7)), 16'($urandom_range(65535)));
                end
            end
        end
        steady = 1'b0;
        wait_for_idle();

        $display("%0d scan beats and %0d keymap beats, %0d reports compared",
                 n_scans, n_loads, report_count);
        $display("fn_code taken through reset value, 0x0004, 0x00E3, 0xFFFF and 0x0000");
        if (fail_count == 0) begin
            $display("tb_key_matrix_scan_hid_report OK");
        end else begin
            $display("tb_key_matrix_scan_hid_report NOT OK");
        end
        $finish;
    end

endmodule
